// ===== design/frt_pkg.sv =====
// Shared types and constants for the flow round-trip-time table.
// Used by frt_ctrl, frt_dp and flow_rtt_table; depends on nothing.
package frt_pkg;

	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int PROTO_W = 8;
	localparam int RTT_W   = 16;
	localparam int KEY_W   = 2 * IP_W + 2 * PORT_W + PROTO_W;
	localparam int ENTRY_W = KEY_W + RTT_W;

	localparam logic [PROTO_W-1:0] TCP_PROTO = 8'd6;

	typedef enum logic {
		ACT_LOOKUP = 1'b0,
		ACT_INSERT = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture the incoming beat, clear scan trackers
		logic scan;      // issue one table read and advance the address
		logic commit;    // write the table and load the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last; // the address being issued is the last entry
	} status_t;

endpackage

// ===== design/frt_ctrl.sv =====
// Controller state machine for the flow round-trip-time table.
// Depends on frt_pkg; drives frt_dp through frt_pkg::cmd_t.
module frt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  frt_pkg::status_t  status,
	output frt_pkg::cmd_t     cmd
);

	frt_pkg::state_t state_q;
	frt_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	// result register can take a new beat if empty or being drained now
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != frt_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.scan    = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			frt_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = frt_pkg::ST_SCAN;
				end
			end
			frt_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) begin
					state_d = frt_pkg::ST_DRAIN;
				end
			end
			frt_pkg::ST_DRAIN: begin
				state_d = frt_pkg::ST_FINISH;
			end
			frt_pkg::ST_FINISH: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = frt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = frt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/frt_dp.sv =====
// Datapath for the flow round-trip-time table: entry memory, valid bits,
// scan address, compare stage and result register. Depends on frt_pkg.
module frt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  frt_pkg::cmd_t                 cmd,
	output frt_pkg::status_t              status,
	input  logic                          action,
	input  logic [frt_pkg::IP_W-1:0]      src_ip,
	input  logic [frt_pkg::IP_W-1:0]      dst_ip,
	input  logic [frt_pkg::PORT_W-1:0]    cli_port,
	input  logic [frt_pkg::PORT_W-1:0]    srv_port,
	input  logic [frt_pkg::PROTO_W-1:0]   proto,
	input  logic [frt_pkg::RTT_W-1:0]     rtt_value,
	output logic [frt_pkg::RTT_W-1:0]     rtt_out,
	output logic                          found
);

	localparam int ENTRIES = frt_pkg::ENTRIES;
	localparam int IDX_W   = frt_pkg::IDX_W;
	localparam int KEY_W   = frt_pkg::KEY_W;
	localparam int RTT_W   = frt_pkg::RTT_W;
	localparam int ENTRY_W = frt_pkg::ENTRY_W;

	// entry memory: key in the upper bits, time in the lower bits
	logic [ENTRY_W-1:0] mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	// captured item
	frt_pkg::action_t   act_q;
	logic [KEY_W-1:0]   key_q;
	logic [RTT_W-1:0]   rtt_q;

	// scan address and read stage
	logic [IDX_W-1:0]   addr_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [ENTRY_W-1:0] rd_data_s1;
	logic               rd_entry_vld_s1;

	// trackers
	logic               match_hit_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic [RTT_W-1:0]   match_rtt_q;
	logic               free_hit_q;
	logic [IDX_W-1:0]   free_idx_q;

	// result register
	logic [RTT_W-1:0]   rtt_out_q;
	logic               found_q;

	logic               key_eq;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic               res_found;
	logic [RTT_W-1:0]   res_rtt;

	assign status.scan_last = (addr_q == IDX_W'(ENTRIES - 1));
	assign key_eq = (rd_data_s1[ENTRY_W-1:RTT_W] == key_q);
	assign rtt_out = rtt_out_q;
	assign found   = found_q;

	// capture the beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= frt_pkg::action_t'(action);
			key_q <= {src_ip, dst_ip, cli_port, srv_port, proto};
			rtt_q <= rtt_value;
		end
	end

	// scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.scan) begin
				addr_q <= addr_q + IDX_W'(1);
			end
		end
	end

	// registered memory read
	always_ff @(posedge clk) begin
		rd_data_s1      <= mem[addr_q];
		rd_entry_vld_s1 <= valid_q[addr_q];
		rd_idx_s1       <= addr_q;
	end

	// track first valid match and first free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
		end else if (cmd.load) begin
			match_hit_q <= 1'b0;
			free_hit_q  <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_entry_vld_s1 && key_eq && !match_hit_q) begin
				match_hit_q <= 1'b1;
			end
			if (!rd_entry_vld_s1 && !free_hit_q) begin
				free_hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && rd_entry_vld_s1 && key_eq && !match_hit_q) begin
			match_idx_q <= rd_idx_s1;
			match_rtt_q <= rd_data_s1[RTT_W-1:0];
		end
		if (rd_vld_s1 && !rd_entry_vld_s1 && !free_hit_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	// resolve the item
	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = match_idx_q;
		res_found = 1'b0;
		res_rtt   = '0;
		unique case (act_q)
			frt_pkg::ACT_LOOKUP: begin
				if (match_hit_q && key_q[frt_pkg::PROTO_W-1:0] == frt_pkg::TCP_PROTO) begin
					res_found = 1'b1;
					res_rtt   = match_rtt_q;
				end
			end
			frt_pkg::ACT_INSERT: begin
				priority if (match_hit_q) begin
					wr_en     = 1'b1;
					res_found = 1'b1;
				end else if (free_hit_q) begin
					wr_en     = 1'b1;
					wr_idx    = free_idx_q;
					res_found = 1'b1;
				end
			end
			default: begin
				res_found = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) begin
			mem[wr_idx] <= {key_q, rtt_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rtt_out_q <= res_rtt;
			found_q   <= res_found;
		end
	end

endmodule

// ===== design/flow_rtt_table.sv =====
// Top level of the flow round-trip-time table.
// Joins frt_ctrl and frt_dp; all types and constants come from frt_pkg.
//
// Usage:
//   A fully associative table of flow entries keyed by the 5-tuple.
//   Each input beat carries action (0 lookup, 1 insert/update), the key and
//   rtt_value. Each beat yields exactly one output beat: rtt_out and found.
//   Lookup answers only TCP keys (protocol 6); a miss or non-TCP key gives
//   rtt_out 0 and found 0. Insert updates a matching entry or claims the
//   lowest free slot; when the table is full it is dropped with found 0.
//   Channels: in_valid/in_stall and out_valid/out_stall; a beat moves on a
//   rising edge with valid high and stall low.
//   Timing: one item at a time. The scan reads one entry a cycle from a
//   memory with registered read, then drains the read stage before the
//   result is loaded; in_stall drops the cycle after, so a new beat is
//   taken only once the previous item has been committed.
//   The result sits in an output register, so the next beat is taken and
//   scanned while an earlier result waits; if the receiver stalls long
//   enough the finished item holds until the register frees.
//   Reset (arst_n low) clears all valid marks at once; no clearing pass.
module flow_rtt_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [frt_pkg::IP_W-1:0]      src_ip,
	input  logic [frt_pkg::IP_W-1:0]      dst_ip,
	input  logic [frt_pkg::PORT_W-1:0]    cli_port,
	input  logic [frt_pkg::PORT_W-1:0]    srv_port,
	input  logic [frt_pkg::PROTO_W-1:0]   proto,
	input  logic [frt_pkg::RTT_W-1:0]     rtt_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [frt_pkg::RTT_W-1:0]     rtt_out,
	output logic                          found
);

	frt_pkg::cmd_t    cmd;
	frt_pkg::status_t status;

	// sequencing: accept, scan every entry, drain the read stage, commit
	frt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// table storage, compare and result register
	frt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.action    (action),
		.src_ip    (src_ip),
		.dst_ip    (dst_ip),
		.cli_port  (cli_port),
		.srv_port  (srv_port),
		.proto     (proto),
		.rtt_value (rtt_value),
		.rtt_out   (rtt_out),
		.found     (found)
	);

endmodule
